FILE: design/rac_pkg.sv
// Package for the radix ASCII converter: widths, stream packing, state codes
// and the digit-to-character mapping. No dependencies.
package rac_pkg;

    // Input field widths as they sit in the slave tdata.
    localparam int VALUE_W    = 64;
    localparam int RADIX_W    = 6;
    localparam int S_TDATA_W  = ((VALUE_W + RADIX_W + 7) / 8) * 8;

    // Number of low value bits that are converted (8 to 64).
    localparam int VALUE_BITS = 64;

    // Base 2 gives the most digits: one per value bit.
    localparam int MAX_DIGITS = VALUE_BITS;
    localparam int STEP_W     = $clog2(VALUE_BITS);
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // Output character and master tdata width.
    localparam int CHAR_W     = 7;
    localparam int M_TDATA_W  = ((CHAR_W + 7) / 8) * 8;

    // Legal radix range and character constants.
    localparam int RADIX_MIN  = 2;
    localparam int RADIX_MAX  = 36;
    localparam int DEC_BASE   = 10;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_SEND
    } t_state;

    // Map a digit value 0..35 onto '0'..'9', 'A'..'Z'.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < RADIX_W'(DEC_BASE)) begin
            return ASCII_ZERO + d_ext;
        end
        return ASCII_A + d_ext - CHAR_W'(DEC_BASE);
    endfunction

endpackage

FILE: design/radix_ascii_converter.sv
// Radix ASCII converter: a bit-serial restoring divider, a digit scratch memory
// and a stream output stage. Uses rac_pkg.
// Each digit takes a pass of the shift-subtract divider over all VALUE_BITS
// value bits; every character is then read back (ST_READ) and sent (ST_SEND),
// where output stalls can hold it. Worst case is base 2 with 64 digits; a bad
// radix gives its single result in the cycle after the request is taken.
// One request is in flight at a time. Synchronous active-low reset returns the
// controller to idle; the scratch memory holds no reset value.
module radix_ascii_converter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Slave side. tdata: value [63:0], radix [69:64], zero pad [71:70].
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [rac_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // Master side. tdata: digit_char [6:0], zero pad [7]. tuser: bad_radix.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rac_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast,
    output logic                           m_axis_tuser
);

    // Controller state and counters.
    rac_pkg::t_state                  r_state;
    rac_pkg::t_state                  n_state;
    logic [rac_pkg::CNT_W-1:0]        r_cnt;
    logic                             r_bad;

    // Divider datapath.
    logic [rac_pkg::VALUE_BITS-1:0]   r_num;
    logic [rac_pkg::RADIX_W-1:0]      r_rem;
    logic [rac_pkg::RADIX_W-1:0]      r_radix;
    logic [rac_pkg::STEP_W-1:0]       r_step;
    logic                             r_qnz;

    // Scratch memory and its registered read port.
    logic [rac_pkg::CHAR_W-1:0]       r_scratch [rac_pkg::MAX_DIGITS];
    logic [rac_pkg::CHAR_W-1:0]       r_rd_data;

    logic                             in_acc;
    logic                             out_acc;
    logic [rac_pkg::RADIX_W-1:0]      in_radix;
    logic                             in_bad;
    logic [rac_pkg::RADIX_W:0]        rem_shift;
    logic [rac_pkg::RADIX_W:0]        rem_diff;
    logic                             qbit;
    logic [rac_pkg::RADIX_W-1:0]      n_rem;
    logic [rac_pkg::VALUE_BITS-1:0]   n_num;
    logic                             last_step;
    logic                             more;
    logic [rac_pkg::CNT_W-1:0]        cnt_dec;
    logic                             last_char;

    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign out_acc  = m_axis_tvalid & m_axis_tready;
    assign in_radix = s_axis_tdata[rac_pkg::VALUE_W +: rac_pkg::RADIX_W];
    assign in_bad   = (in_radix < rac_pkg::RADIX_W'(rac_pkg::RADIX_MIN)) ||
                      (in_radix > rac_pkg::RADIX_W'(rac_pkg::RADIX_MAX));

    // One restoring division step: bring down the next dividend bit and
    // subtract the radix when it fits. Quotient bits shift in at the bottom.
    assign rem_shift = {r_rem, r_num[rac_pkg::VALUE_BITS-1]};
    assign qbit      = rem_shift >= {1'b0, r_radix};
    assign rem_diff  = rem_shift - {1'b0, r_radix};
    assign n_rem     = qbit ? rem_diff[rac_pkg::RADIX_W-1:0]
                            : rem_shift[rac_pkg::RADIX_W-1:0];
    assign n_num     = {r_num[rac_pkg::VALUE_BITS-2:0], qbit};
    assign last_step = (r_step == rac_pkg::STEP_W'(rac_pkg::VALUE_BITS - 1));
    assign more      = r_qnz | qbit;

    assign cnt_dec   = r_cnt - rac_pkg::CNT_W'(1);
    assign last_char = (r_cnt == rac_pkg::CNT_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rac_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = in_bad ? rac_pkg::ST_SEND : rac_pkg::ST_DIV;
                end
            end
            rac_pkg::ST_DIV: begin
                if (last_step) begin
                    n_state = more ? rac_pkg::ST_DIV : rac_pkg::ST_READ;
                end
            end
            rac_pkg::ST_READ: begin
                n_state = rac_pkg::ST_SEND;
            end
            rac_pkg::ST_SEND: begin
                if (out_acc) begin
                    n_state = last_char ? rac_pkg::ST_IDLE : rac_pkg::ST_READ;
                end
            end
            default: begin
                n_state = rac_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (r_state)
            rac_pkg::ST_IDLE: s_axis_tready = 1'b1;
            rac_pkg::ST_SEND: m_axis_tvalid = 1'b1;
            default: begin
                s_axis_tready = 1'b0;
                m_axis_tvalid = 1'b0;
            end
        endcase
    end

    // The error result carries a zero character.
    assign m_axis_tdata = rac_pkg::M_TDATA_W'(r_bad ? '0 : r_rd_data);
    assign m_axis_tlast = last_char;
    assign m_axis_tuser = r_bad;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rac_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_bad <= in_bad;
                r_cnt <= in_bad ? rac_pkg::CNT_W'(1) : '0;
            end else if (r_state == rac_pkg::ST_DIV && last_step) begin
                r_cnt <= r_cnt + rac_pkg::CNT_W'(1);
            end else if (out_acc) begin
                r_cnt <= cnt_dec;
            end
        end
    end

    // Divider registers. After the last step r_num holds the quotient, which
    // becomes the dividend of the next digit.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_num   <= s_axis_tdata[rac_pkg::VALUE_BITS-1:0];
            r_radix <= in_radix;
            r_rem   <= '0;
            r_step  <= '0;
            r_qnz   <= 1'b0;
        end else if (r_state == rac_pkg::ST_DIV) begin
            r_num <= n_num;
            if (last_step) begin
                r_rem  <= '0;
                r_step <= '0;
                r_qnz  <= 1'b0;
            end else begin
                r_rem  <= n_rem;
                r_step <= r_step + rac_pkg::STEP_W'(1);
                r_qnz  <= more;
            end
        end
    end

    // Scratch memory: digits are written least significant first and read
    // back from the top down.
    always_ff @(posedge i_clk) begin
        if (r_state == rac_pkg::ST_DIV && last_step) begin
            r_scratch[r_cnt[rac_pkg::IDX_W-1:0]] <= rac_pkg::digit_to_ascii(n_rem);
        end
        if (r_state == rac_pkg::ST_READ) begin
            r_rd_data <= r_scratch[cnt_dec[rac_pkg::IDX_W-1:0]];
        end
    end

`ifndef ASSERT_OFF
    // The error result is a single, final, zero character.
    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("bad radix result is not a single zero character");

    // The partial remainder stays below the radix while dividing.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rac_pkg::ST_DIV) |-> (r_rem < r_radix))
        else $error("divider remainder out of range");

    // The digit count never exceeds the scratch depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rac_pkg::CNT_W'(rac_pkg::MAX_DIGITS))
        else $error("digit count overflow");

    // A new request is never taken while a result is offered.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request accepted during output");
`endif

endmodule

FILE: dv/radix_ascii_converter_tb.sv
// Self-checking testbench for radix_ascii_converter: directed and random
// conversion requests, a digit predictor and a per-character scoreboard.
// Depends on rac_pkg and the radix_ascii_converter RTL.
`timescale 1ns / 1ps

module radix_ascii_converter_tb;

    // Legal radix range and the two digit character bases.
    localparam int RADIX_LO   = 2;
    localparam int RADIX_HI   = 36;
    localparam int DEC_DIGITS = 10;
    localparam logic [6:0] CH_ZERO     = 7'h30; // '0'
    localparam logic [6:0] CH_LETTER_A = 7'h41; // 'A'

    // Only the low VALUE_BITS bits of a value are converted.
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - rac_pkg::VALUE_BITS);

    // Run control.
    localparam int LONG_HOLD_AT     = 30;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int N_RANDOM         = 115;
    localparam int SETTLE_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT   = 20000;

    typedef struct {
        logic [rac_pkg::VALUE_W-1:0] value;
        logic [rac_pkg::RADIX_W-1:0] radix;
        bit                          drain_first;
    } t_conv_req;

    typedef struct {
        logic [6:0] ch;
        logic       last;
        logic       bad;
    } t_char_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // value [63:0], radix [69:64], zero pad [71:70].
    logic [rac_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // digit_char [6:0], zero pad [7].
    logic [rac_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                          m_axis_tlast;
    // bad_radix.
    logic                          m_axis_tuser;

    t_conv_req    pending_convs[$];
    t_char_result expected_chars[$];

    t_conv_req cur_req;
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    int n_accepted  = 0;
    int n_total     = 0;
    int n_errors    = 0;
    int idle_cycles = 0;
    int send_gap    = 0;
    int send_calm   = 0;
    int recv_stall  = 0;
    int recv_calm   = 0;
    bit long_hold_done = 1'b0;

    radix_ascii_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Work out the characters of one conversion, most significant first.
    task automatic predict_chars(input logic [63:0] value, input logic [5:0] radix);
        logic [63:0] num;
        logic [63:0] digit;
        logic [6:0]  msd_first[$];
        t_char_result res;
        num = value & VALUE_MASK;
        res.bad = 1'b0;
        if (radix < RADIX_LO || radix > RADIX_HI) begin
            res.ch   = '0;
            res.last = 1'b1;
            res.bad  = 1'b1;
            expected_chars.push_back(res);
        end else if (num == 0) begin
            res.ch   = CH_ZERO;
            res.last = 1'b1;
            expected_chars.push_back(res);
        end else begin
            while (num != 0) begin
                digit = num % 64'(radix);
                if (digit < DEC_DIGITS) begin
                    msd_first.push_front(CH_ZERO + 7'(digit));
                end else begin
                    msd_first.push_front(CH_LETTER_A + 7'(digit - DEC_DIGITS));
                end
                num = num / 64'(radix);
            end
            foreach (msd_first[i]) begin
                res.ch   = msd_first[i];
                res.last = (i == msd_first.size() - 1);
                expected_chars.push_back(res);
            end
        end
    endtask

    task automatic add_conv(input logic [63:0] value, input logic [5:0] radix,
                            input bit drain_first);
        t_conv_req r;
        r.value       = value;
        r.radix       = radix;
        r.drain_first = drain_first;
        pending_convs.push_back(r);
        n_total++;
    endtask

    // Idle cycles before the next transfer, with occasional runs of none.
    task automatic draw_idle(inout int calm_left, output int cycles);
        if (calm_left > 0) begin
            calm_left--;
            cycles = 0;
        end else begin
            if ($urandom_range(0, 15) == 0) begin
                calm_left = $urandom_range(8, 30);
            end
            cycles = $urandom_range(0, 12);
        end
    endtask

    // Request driver: presents queued conversions at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_convs.size() == 0 ||
                         (pending_convs[0].drain_first && expected_chars.size() != 0)) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                cur_req = pending_convs.pop_front();
                s_axis_tdata  <= {{(rac_pkg::S_TDATA_W - rac_pkg::VALUE_W -
                                    rac_pkg::RADIX_W){1'b0}},
                                  cur_req.radix, cur_req.value};
                s_axis_tvalid <= 1'b1;
                draw_idle(send_calm, send_gap);
            end
        end
    end

    // Character receiver: random stalls plus one long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (!long_hold_done && n_accepted >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            recv_stall = LONG_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end else if (out_fire) begin
            draw_idle(recv_calm, recv_stall);
            m_axis_tready <= (recv_stall == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: checks each character and predicts each accepted request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire     <= 1'b0;
            out_fire    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_fire  <= s_axis_tvalid && s_axis_tready;
            out_fire <= m_axis_tvalid && m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected character: expected none, %s %h last %b bad %b",
                             $time, "got tdata", m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end else begin
                    t_char_result want;
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== rac_pkg::M_TDATA_W'(want.ch) ||
                        m_axis_tlast !== want.last ||
                        m_axis_tuser !== want.bad) begin
                        n_errors++;
                        $display("%0t: character mismatch: expected tdata %h last %b bad %b,",
                                 $time, rac_pkg::M_TDATA_W'(want.ch), want.last, want.bad);
                        $display("    got tdata %h last %b bad %b",
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_chars(s_axis_tdata[rac_pkg::VALUE_W-1:0],
                              s_axis_tdata[rac_pkg::VALUE_W +: rac_pkg::RADIX_W]);
                n_accepted <= n_accepted + 1;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("** radix_ascii_converter: FAILED **");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        logic [63:0] val;
        logic [5:0]  rdx;
        int k;

        // Zero, all ones in the common bases, the largest digit count.
        add_conv(64'd0, 6'd10, 1'b0);
        add_conv(64'd0, 6'd2, 1'b0);
        add_conv({64{1'b1}}, 6'd2, 1'b0);
        add_conv({64{1'b1}}, 6'd36, 1'b0);
        add_conv({64{1'b1}}, 6'd16, 1'b0);
        add_conv({64{1'b1}}, 6'd10, 1'b0);
        add_conv({64{1'b1}}, 6'd8, 1'b0);
        add_conv({64{1'b1}}, 6'd3, 1'b0);
        add_conv(64'h8000_0000_0000_0000, 6'd2, 1'b0);
        add_conv(64'h0123_4567_89AB_CDEF, 6'd16, 1'b0);
        // Single digits at the edges of the digit alphabet, and the first two-digit value in base 36.
        add_conv(64'd1, 6'd36, 1'b0);
        add_conv(64'd9, 6'd10, 1'b0);
        add_conv(64'd10, 6'd11, 1'b0);
        add_conv(64'd35, 6'd36, 1'b0);
        add_conv(64'd36, 6'd36, 1'b0);
        add_conv(64'd31, 6'd32, 1'b0);
        add_conv(64'd1, 6'd2, 1'b0);
        // Radix out of range on both sides, with zero and nonzero values.
        add_conv(64'd12345, 6'd0, 1'b0);
        add_conv(64'd12345, 6'd1, 1'b0);
        add_conv(64'd0, 6'd1, 1'b0);
        add_conv({64{1'b1}}, 6'd37, 1'b0);
        add_conv(64'h5A5A_A5A5_0F0F_F0F0, 6'd63, 1'b0);
        add_conv(64'd0, 6'd63, 1'b0);

        // Random part: mostly legal radixes, values of assorted sizes.
        for (k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(0, 5))
                0, 1: val = {$urandom, $urandom};
                2: val = 64'($urandom_range(0, 999));
                3: val = 64'd1 << $urandom_range(0, 63);
                4: val = {$urandom, $urandom} >> $urandom_range(0, 63);
                default: val = (64'd1 << $urandom_range(1, 63)) - 64'd1;
            endcase
            if ($urandom_range(0, 39) == 0) begin
                val = 64'd0;
            end
            if ($urandom_range(0, 9) == 0) begin
                rdx = 6'($urandom_range(0, 63));
            end else begin
                rdx = 6'($urandom_range(RADIX_LO, RADIX_HI));
            end
            add_conv(val, rdx, (k == 0) || ($urandom_range(0, 14) == 0));
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_total) @(negedge i_clk);
        while (expected_chars.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (n_errors == 0) begin
            $display("** radix_ascii_converter: PASSED **");
        end else begin
            $display("** radix_ascii_converter: FAILED **");
        end
        $finish;
    end

endmodule
